FILE: sv/svw_pkg.sv
// Package for spatial_vertex_weld: shared types and fixed widths.
// No dependencies.
package svw_pkg;
    localparam int CoordW = 32;
    localparam int TolW   = 16;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_MIN_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_X = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_Y = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MAX_Y = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MIN_Z = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MAX_Z = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_POS_TOL = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_TEX_TOL = 3'd7;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic signed [CoordW-1:0] u;
        logic signed [CoordW-1:0] v;
    } vert_t;

    // true when |a-b| < tol, exact at 33 bits
    function automatic logic close_enough(input logic signed [CoordW-1:0] a,
                                          input logic signed [CoordW-1:0] b,
                                          input logic [TolW-1:0] tol);
        logic signed [CoordW:0] d;
        logic [CoordW:0] m;
        begin
            d = CoordW'(0) + ({a[CoordW-1], a} - {b[CoordW-1], b});
            m = d[CoordW] ? (~d + 1'b1) : d;
            close_enough = m < {{(CoordW+1-TolW){1'b0}}, tol};
        end
    endfunction
endpackage

FILE: sv/svw_descend.sv
// Tree descent: one split level per cycle, axes cycling X, Z, Y.
// Depends on svw_pkg.
module svw_descend #(
    parameter int LEVELS = 9
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic signed [svw_pkg::CoordW-1:0] px, py, pz,
    input  logic signed [svw_pkg::CoordW-1:0] min_x, max_x, min_y, max_y, min_z, max_z,
    output logic done,
    output logic [LEVELS-1:0] leaf
);
    import svw_pkg::*;

    logic signed [CoordW-1:0] lo_reg [3];
    logic signed [CoordW-1:0] hi_reg [3];
    logic [LEVELS-1:0] path_reg;
    logic [$clog2(LEVELS+1)-1:0] cnt_reg;
    logic [1:0] ax_reg;
    logic busy_reg, done_reg;
    logic signed [CoordW:0] sum;
    logic signed [CoordW-1:0] mid, p;
    logic [1:0] ax_next;

    always_comb begin
        sum = {lo_reg[ax_reg][CoordW-1], lo_reg[ax_reg]}
            + {hi_reg[ax_reg][CoordW-1], hi_reg[ax_reg]};
        mid = sum[CoordW:1];
        case (ax_reg)
            2'd0: p = px;
            2'd1: p = py;
            default: p = pz;
        endcase
        // X -> Z -> Y -> X
        case (ax_reg)
            2'd0: ax_next = 2'd2;
            2'd2: ax_next = 2'd1;
            default: ax_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            ax_reg   <= 2'd0;
            lo_reg[0] <= min_x; hi_reg[0] <= max_x;
            lo_reg[1] <= min_y; hi_reg[1] <= max_y;
            lo_reg[2] <= min_z; hi_reg[2] <= max_z;
        end else if (busy_reg) begin
            if (p < mid) hi_reg[ax_reg] <= mid;
            else         lo_reg[ax_reg] <= mid;
            path_reg <= {path_reg[LEVELS-2:0], ~(p < mid)};
            ax_reg   <= ax_next;
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(LEVELS+1))'(LEVELS-1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                done_reg <= 1'b0;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign leaf = path_reg;
endmodule

FILE: sv/svw_store.sv
// Vertex store and leaf lists: bucket walk, match and append.
// Depends on svw_pkg; uses synchronous memories with registered reads.
module svw_store #(
    parameter int LEAF_COUNT = 512,
    parameter int VERTEX_CAPACITY = 4096
) (
    input  logic aclk,
    input  logic aresetn,
    output logic clearing,
    input  logic start,
    input  logic [$clog2(LEAF_COUNT)-1:0] leaf,
    input  svw_pkg::vert_t vin,
    input  logic [svw_pkg::TolW-1:0] pos_tol,
    input  logic [svw_pkg::TolW-1:0] tex_tol,
    output logic done,
    output logic [$clog2(VERTEX_CAPACITY)-1:0] index,
    output logic inserted,
    output logic full
);
    import svw_pkg::*;
    localparam int LW = $clog2(LEAF_COUNT);
    localparam int VW = $clog2(VERTEX_CAPACITY);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_HEAD = 6'b000100,
        S_CMP  = 6'b001000,
        S_INS  = 6'b010000,
        S_LINK = 6'b100000
    } state_t;

    // leaf_head: valid + index, cleared after reset by a sweep
    logic [VW:0]   head_mem [LEAF_COUNT];
    logic [VW-1:0] tail_mem [LEAF_COUNT];
    logic [VW:0]   next_mem [VERTEX_CAPACITY];
    vert_t         vert_mem [VERTEX_CAPACITY];

    state_t state_reg;
    logic [LW:0]  clr_reg;
    logic [VW:0]  count_reg;
    logic [VW:0]  head_q, next_q;
    logic [VW-1:0] tail_q;
    vert_t        vert_q;
    logic [VW-1:0] cur_reg;
    logic [VW-1:0] rd_addr;
    logic         rd_en;
    logic         head_valid_reg;
    logic [VW-1:0] idx_reg;
    logic ins_reg, full_reg, done_reg;
    logic done_next;
    logic match;

    assign match = close_enough(vin.x, vert_q.x, pos_tol) &&
                   close_enough(vin.y, vert_q.y, pos_tol) &&
                   close_enough(vin.z, vert_q.z, pos_tol) &&
                   close_enough(vin.u, vert_q.u, tex_tol) &&
                   close_enough(vin.v, vert_q.v, tex_tol);

    // vertex read port
    always_comb begin
        rd_en = 1'b0;
        rd_addr = cur_reg;
        if (state_reg == S_HEAD) begin
            rd_en = head_q[VW];
            rd_addr = head_q[VW-1:0];
        end else if (state_reg == S_CMP && !match) begin
            rd_en = next_q[VW];
            rd_addr = next_q[VW-1:0];
        end
    end

    always_comb begin
        case (state_reg)
            S_CMP:   done_next = match;
            S_INS:   done_next = full_reg || !head_valid_reg;
            S_LINK:  done_next = 1'b1;
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        head_q <= head_mem[leaf];
        tail_q <= tail_mem[leaf];
        if (rd_en) begin
            vert_q <= vert_mem[rd_addr];
            next_q <= next_mem[rd_addr];
        end
        if (state_reg == S_CLR) head_mem[clr_reg[LW-1:0]] <= '0;
        if (state_reg == S_INS && !full_reg) begin
            vert_mem[count_reg[VW-1:0]] <= vin;
            next_mem[count_reg[VW-1:0]] <= '0;
            tail_mem[leaf] <= count_reg[VW-1:0];
            if (!head_valid_reg) head_mem[leaf] <= {1'b1, count_reg[VW-1:0]};
        end
        if (state_reg == S_LINK) next_mem[tail_q] <= {1'b1, idx_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= done_next;
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (LW+1)'(LEAF_COUNT-1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (start) state_reg <= S_HEAD;
                S_HEAD: begin
                    head_valid_reg <= head_q[VW];
                    cur_reg <= head_q[VW-1:0];
                    if (head_q[VW]) state_reg <= S_CMP;
                    else begin
                        full_reg  <= count_reg == (VW+1)'(VERTEX_CAPACITY);
                        state_reg <= S_INS;
                    end
                end
                S_CMP: begin
                    if (match) begin
                        idx_reg <= cur_reg; ins_reg <= 1'b0; full_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else if (next_q[VW]) begin
                        cur_reg <= next_q[VW-1:0];
                    end else begin
                        full_reg  <= count_reg == (VW+1)'(VERTEX_CAPACITY);
                        state_reg <= S_INS;
                    end
                end
                S_INS: begin
                    if (full_reg) begin
                        idx_reg <= '0; ins_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg <= count_reg[VW-1:0]; ins_reg <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        if (head_valid_reg) state_reg <= S_LINK;
                        else state_reg <= S_IDLE;
                    end
                end
                S_LINK: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign clearing = state_reg == S_CLR;
    assign done = done_reg;
    assign index = idx_reg;
    assign inserted = ins_reg;
    assign full = full_reg;
endmodule

FILE: sv/spatial_vertex_weld.sv
// spatial_vertex_weld: welds incoming vertices against a bucketed store.
// Usage:
//   s_axis_* carries one vertex request: tdata = pos_x, pos_y, pos_z,
//   tex_u, tex_v (32 bits each, from bit 0 up). m_axis_* returns one result:
//   tdata = vertex_index[11:0], was_inserted, store_full, leaf_number[8:0].
//   Config: cfg_we/cfg_index/cfg_data, which the user must write only
//   while idle; the block itself does no check of this.
// Flow: tree descent over log2(LEAF_COUNT) levels (one split per cycle),
//   then a head read, a walk over the bucket entries and, if none
//   matches, an append. One vertex is in work at a time; the next request
//   is taken only after the result has left the output register.
// Reset: aresetn (synchronous, low) clears control and config registers,
//   then a sweep over all LEAF_COUNT entries empties the leaf head memory;
//   no request is accepted during it.
// Stall: while m_axis_tready holds a result back, s_axis_tready stays low.
module spatial_vertex_weld #(
    parameter int LEAF_COUNT = 512,
    parameter int VERTEX_CAPACITY = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_index[11:0], was_inserted, store_full, leaf_number[8:0]
    output logic [23:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [svw_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);
    import svw_pkg::*;
    localparam int LW = $clog2(LEAF_COUNT);
    localparam int VW = $clog2(VERTEX_CAPACITY);

    logic signed [CoordW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [CoordW-1:0] min_z_reg, max_z_reg;
    logic [TolW-1:0] ptol_reg, ttol_reg;
    vert_t vin_reg;
    logic busy_reg, out_valid_reg;
    logic [23:0] out_reg;
    logic desc_done, st_done, clearing, ins, full;
    logic [LW-1:0] leaf;
    logic [VW-1:0] idx;
    logic [11:0] idx12;
    logic [8:0] leaf9;
    logic accept;

    assign s_axis_tready = aresetn && !busy_reg && !clearing && !out_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0; max_x_reg <= '0; min_y_reg <= '0;
            max_y_reg <= '0; min_z_reg <= '0; max_z_reg <= '0;
            ptol_reg <= 16'd26; ttol_reg <= 16'd66;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_MAX_Z: max_z_reg <= cfg_data;
                REG_POS_TOL: ptol_reg <= cfg_data[TolW-1:0];
                REG_TEX_TOL: ttol_reg <= cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vin_reg.x <= s_axis_tdata[31:0];
            vin_reg.y <= s_axis_tdata[63:32];
            vin_reg.z <= s_axis_tdata[95:64];
            vin_reg.u <= s_axis_tdata[127:96];
            vin_reg.v <= s_axis_tdata[159:128];
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) busy_reg <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            if (st_done) begin
                busy_reg <= 1'b0;
                out_valid_reg <= 1'b1;
                out_reg <= {1'b0, leaf9, full, ins, idx12};
            end
        end
    end

    always_comb begin
        idx12 = '0; leaf9 = '0;
        idx12[((VW < 12) ? VW : 12)-1:0] = idx[((VW < 12) ? VW : 12)-1:0];
        leaf9[((LW < 9) ? LW : 9)-1:0] = leaf[((LW < 9) ? LW : 9)-1:0];
    end

    svw_descend #(.LEVELS(LW)) u_desc (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .px(vin_reg.x), .py(vin_reg.y), .pz(vin_reg.z),
        .min_x(min_x_reg), .max_x(max_x_reg), .min_y(min_y_reg),
        .max_y(max_y_reg), .min_z(min_z_reg), .max_z(max_z_reg),
        .done(desc_done), .leaf(leaf)
    );

    svw_store #(.LEAF_COUNT(LEAF_COUNT), .VERTEX_CAPACITY(VERTEX_CAPACITY)) u_store (
        .aclk(aclk), .aresetn(aresetn), .clearing(clearing),
        .start(desc_done), .leaf(leaf), .vin(vin_reg),
        .pos_tol(ptol_reg), .tex_tol(ttol_reg),
        .done(st_done), .index(idx), .inserted(ins), .full(full)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
endmodule
